// File: sv/art_pkg.sv
package art_pkg;

    localparam int MaxRegions = 16;
    localparam int PageBits   = 12;
    localparam int SlotBits   = $clog2(MaxRegions);
    localparam logic [31:0] PageSize = 32'd1 << PageBits;
    localparam logic [31:0] PageMask = PageSize - 32'd1;
    localparam logic [2:0]  FullRights = 3'd7;

    localparam logic [2:0] CmdRegion = 3'd0;
    localparam logic [2:0] CmdStack  = 3'd1;
    localparam logic [2:0] CmdHeap   = 3'd2;
    localparam logic [2:0] CmdBrk    = 3'd3;
    localparam logic [2:0] CmdCheck  = 3'd4;

    localparam logic [2:0] StOk      = 3'd0;
    localparam logic [2:0] StOverlap = 3'd1;
    localparam logic [2:0] StFull    = 3'd2;
    localparam logic [2:0] StHeapHit = 3'd3;
    localparam logic [2:0] StNoDef   = 3'd4;
    localparam logic [2:0] StNotFnd  = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // one table entry as it travels along the chain
    typedef struct packed {
        logic        used;
        logic [31:0] base;
        logic [31:0] top;
        logic [2:0]  rights;
    } t_entry;

    function automatic logic [31:0] round_up(input logic [31:0] v);
        round_up = (v + PageMask) & ~PageMask;
    endfunction

    function automatic logic overlaps(input logic [31:0] b1, input logic [31:0] t1,
                                      input logic [31:0] b2, input logic [31:0] t2);
        overlaps = !(((b1 < b2) && (t1 <= b2)) || ((b1 >= t2) && (t1 >= t2)));
    endfunction

endpackage

// File: sv/art_cell.sv
module art_cell
    import art_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_shift,
    input  t_entry i_prev,
    output t_entry o_entry
);

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.used <= 1'b0;
        end else if (i_shift) begin
            r_entry.used <= i_prev.used;
        end
        if (i_shift) begin
            r_entry.base   <= i_prev.base;
            r_entry.top    <= i_prev.top;
            r_entry.rights <= i_prev.rights;
        end
    end

    assign o_entry = r_entry;

endmodule

// File: sv/address_region_table_unit.sv
// Command unit for a table of page-aligned address regions with one stack and one heap.
// A command is taken when i_start is high and o_busy low; one result follows on
// o_valid for a single cycle and cannot be held off by the receiver. The table is a
// chain of MaxRegions cells, newest entry at the head; for every command the chain
// rotates once past a single compare stage (S_SCAN), then S_DONE resolves the command,
// updates the table, stack and heap (an insertion shifts the new entry in at the head)
// and loads the output registers. The result is therefore registered and shown while
// the unit is back in S_IDLE, for every command alike, and the next command can be
// taken at the same edge that transfers the result.
module address_region_table_unit
    import art_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [2:0]  i_cmd,
    input  logic [31:0] i_addr,
    input  logic [31:0] i_size,
    input  logic [2:0]  i_rights,
    output logic        o_busy,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [31:0] o_value,
    output logic [2:0]  o_rights_out,
    output logic        o_in_bounds
);

    t_entry cells [MaxRegions];
    t_entry feed;
    t_entry tail;
    t_entry new_entry;
    logic   shift;
    logic   ins;
    logic   fin;

    t_state r_state, n_state;
    logic [2:0]          r_cmd;
    logic [31:0]         r_addr, r_size, r_b, r_t, r_g;
    logic [2:0]          r_rights;
    logic [SlotBits-1:0] r_step;
    logic                r_clash, r_found, r_zhit;
    logic [31:0]         r_ftop, r_hmax;
    logic [2:0]          r_frights;
    logic [31:0]         r_sb, r_st, r_hb, r_ht;
    logic                r_sdef, r_hdef;
    logic                r_ovalid, r_oinb;
    logic [2:0]          r_ostatus, r_orights;
    logic [31:0]         r_ovalue;

    logic        full;
    logic [31:0] hnew, a_end, top_sel, n_ht;
    logic        hit_stack, hit_heap;
    logic [2:0]  n_status, n_rights;
    logic [31:0] n_value;
    logic        n_inb;
    logic        set_stack, set_heap, set_ht;

    genvar gi;
    generate
        for (gi = 0; gi < MaxRegions; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                art_cell u_cell (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_shift(shift),
                                 .i_prev(feed), .o_entry(cells[gi]));
            end else begin : g_body
                art_cell u_cell (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_shift(shift),
                                 .i_prev(cells[gi-1]), .o_entry(cells[gi]));
            end
        end
    endgenerate

    // oldest entries reach the tail first, so the last match is the newest
    assign tail  = cells[MaxRegions-1];
    assign fin   = (r_step == SlotBits'(MaxRegions - 1));
    assign shift = (r_state == S_SCAN) || ins;
    assign feed  = ins ? new_entry : tail;

    // resolve the command once the chain is back at rest
    always_comb begin
        full      = cells[MaxRegions-1].used;
        hnew      = round_up(r_hmax);
        a_end     = r_addr + r_size;
        hit_stack = r_sdef && (r_sb <= r_addr) && (r_addr < r_st);
        hit_heap  = r_hdef && (r_hb <= r_addr) && (r_addr < r_ht);
        n_status  = StOk;
        n_value   = '0;
        n_rights  = '0;
        n_inb     = 1'b0;
        top_sel   = '0;
        ins       = 1'b0;
        new_entry = '0;
        set_stack = 1'b0;
        set_heap  = 1'b0;
        set_ht    = 1'b0;
        n_ht      = r_ht;
        if (r_state == S_DONE) begin
            case (r_cmd)
                CmdRegion: begin
                    if (full) begin
                        n_status = StFull;
                    end else if (r_clash || (r_sdef && overlaps(r_b, r_t, r_sb, r_st))) begin
                        n_status = StOverlap;
                    end else begin
                        ins              = 1'b1;
                        new_entry.used   = 1'b1;
                        new_entry.base   = r_b;
                        new_entry.top    = r_t;
                        new_entry.rights = r_rights;
                    end
                end
                CmdStack: begin
                    if (full) begin
                        n_status = StFull;
                    end else if (r_clash || (r_sdef && (overlaps(r_b, r_t, r_sb, r_st) ||
                                                        overlaps(r_g, r_b, r_sb, r_st)))) begin
                        n_status = StOverlap;
                    end else begin
                        // guard page below the stack, no rights
                        ins              = 1'b1;
                        new_entry.used   = 1'b1;
                        new_entry.base   = r_g;
                        new_entry.top    = r_b;
                        new_entry.rights = 3'd0;
                        set_stack        = 1'b1;
                    end
                end
                CmdHeap: begin
                    if (!r_sdef) begin
                        n_status = StNoDef;
                    end else if (hnew > r_sb) begin
                        n_status = StHeapHit;
                    end else if (overlaps(hnew, hnew, r_sb, r_st) ||
                                 (hnew == '0 && r_zhit)) begin
                        // a non-wrapped heap base is at or above every table top
                        n_status = StOverlap;
                    end else begin
                        set_heap = 1'b1;
                    end
                end
                CmdBrk: begin
                    if (!r_hdef) begin
                        n_status = StNoDef;
                    end else if (r_addr == '0) begin
                        n_value = r_ht;
                    end else if (r_addr < r_hb) begin
                        set_ht  = 1'b1;
                        n_ht    = r_hb;
                        n_value = r_hb;
                    end else if (r_clash || (r_sdef && overlaps(r_hb, r_addr, r_sb, r_st))) begin
                        n_status = StOverlap;
                    end else begin
                        set_ht  = 1'b1;
                        n_ht    = r_addr;
                        n_value = r_addr;
                    end
                end
                CmdCheck: begin
                    if (hit_stack) begin
                        top_sel  = r_st;
                        n_rights = FullRights;
                    end else if (hit_heap) begin
                        top_sel  = r_ht;
                        n_rights = FullRights;
                    end else if (r_found) begin
                        top_sel  = r_ftop;
                        n_rights = r_frights;
                    end
                    if (hit_stack || hit_heap || r_found)
                        n_inb = (a_end < top_sel);
                    else
                        n_status = StNotFnd;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_start) n_state = S_SCAN;
            S_SCAN: if (fin) n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sdef   <= 1'b0;
            r_hdef   <= 1'b0;
            r_ovalid <= 1'b0;
            r_sb     <= '0;
            r_st     <= '0;
            r_hb     <= '0;
            r_ht     <= '0;
        end else begin
            r_ovalid <= (r_state == S_DONE);
            if (set_stack) begin
                r_sb   <= r_b;
                r_st   <= r_t;
                r_sdef <= 1'b1;
            end
            if (set_heap) begin
                r_hb   <= hnew;
                r_ht   <= hnew;
                r_hdef <= 1'b1;
            end else if (set_ht) begin
                r_ht <= n_ht;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_cmd     <= i_cmd;
            r_addr    <= i_addr;
            r_size    <= i_size;
            r_rights  <= i_rights;
            r_step    <= '0;
            r_clash   <= 1'b0;
            r_found   <= 1'b0;
            r_zhit    <= 1'b0;
            r_hmax    <= PageSize;
            r_ftop    <= '0;
            r_frights <= '0;
            case (i_cmd)
                CmdRegion: begin
                    r_b <= i_addr & ~PageMask;
                    r_t <= (i_addr & ~PageMask) + round_up(i_size);
                    r_g <= '0;
                end
                CmdStack: begin
                    r_t <= i_addr & ~PageMask;
                    r_b <= (i_addr & ~PageMask) - round_up(i_size);
                    r_g <= (i_addr & ~PageMask) - round_up(i_size) - PageSize;
                end
                default: begin
                    r_b <= r_hb;
                    r_t <= i_addr;
                    r_g <= '0;
                end
            endcase
        end
        if (r_state == S_SCAN) begin
            r_step <= r_step + SlotBits'(1);
            if (tail.used) begin
                if (overlaps(r_b, r_t, tail.base, tail.top) ||
                    (r_cmd == CmdStack && overlaps(r_g, r_b, tail.base, tail.top)))
                    r_clash <= 1'b1;
                if (tail.top > r_hmax)
                    r_hmax <= tail.top;
                if (tail.base == '0 && tail.top != '0)
                    r_zhit <= 1'b1;
                if (tail.base <= r_addr && r_addr < tail.top) begin
                    r_found   <= 1'b1;
                    r_ftop    <= tail.top;
                    r_frights <= tail.rights;
                end
            end
        end
        if (r_state == S_DONE) begin
            r_ostatus <= n_status;
            r_ovalue  <= n_value;
            r_orights <= n_rights;
            r_oinb    <= n_inb;
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_status     = r_ostatus;
    assign o_value      = r_ovalue;
    assign o_rights_out = r_orights;
    assign o_in_bounds  = r_oinb;

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

class region_scoreboard;
    logic [31:0] tbl_base [art_pkg::MaxRegions];
    logic [31:0] tbl_top [art_pkg::MaxRegions];
    logic [2:0] tbl_rights [art_pkg::MaxRegions];
    int n_used;
    logic [31:0] stk_base, stk_top, heap_lo, heap_top;
    bit stk_def, heap_def;
    logic [38:0] pending [$];
    int errors;

    function new();
        n_used = 0;
        stk_def = 0;
        heap_def = 0;
        stk_base = 0;
        stk_top = 0;
        heap_lo = 0;
        heap_top = 0;
        errors = 0;
    endfunction

    function bit hits(logic [31:0] b1, logic [31:0] t1, logic [31:0] b2, logic [31:0] t2);
        return !(((b1 < b2) && (t1 <= b2)) || ((b1 >= t2) && (t1 >= t2)));
    endfunction

    function logic [31:0] page_up(logic [31:0] v);
        return (v + art_pkg::PageMask) & ~art_pkg::PageMask;
    endfunction

    function bit clashes(logic [31:0] b, logic [31:0] t);
        if (stk_def && hits(b, t, stk_base, stk_top)) return 1;
        for (int i = 0; i < n_used; i++)
            if (hits(b, t, tbl_base[i], tbl_top[i])) return 1;
        return 0;
    endfunction

    function void add_entry(logic [31:0] b, logic [31:0] t, logic [2:0] r);
        tbl_base[n_used] = b;
        tbl_top[n_used] = t;
        tbl_rights[n_used] = r;
        n_used++;
    endfunction

    // predict the reply to one accepted command
    function void note_command(logic [2:0] cmd, logic [31:0] addr, logic [31:0] size,
                               logic [2:0] rights);
        logic [2:0] st;
        logic [31:0] val, b, t, g, hb, top;
        logic [2:0] rout;
        logic inb;
        bit found;
        st = art_pkg::StOk;
        val = 0;
        rout = 0;
        inb = 0;
        found = 0;
        top = 0;
        case (cmd)
            art_pkg::CmdRegion: begin
                b = addr & ~art_pkg::PageMask;
                t = b + page_up(size);
                if (n_used >= art_pkg::MaxRegions) st = art_pkg::StFull;
                else if (clashes(b, t)) st = art_pkg::StOverlap;
                else add_entry(b, t, rights);
            end
            art_pkg::CmdStack: begin
                t = addr & ~art_pkg::PageMask;
                b = t - page_up(size);
                g = b - art_pkg::PageSize;
                if (n_used >= art_pkg::MaxRegions) st = art_pkg::StFull;
                else if (clashes(b, t) || clashes(g, b)) st = art_pkg::StOverlap;
                else begin
                    stk_base = b;
                    stk_top = t;
                    stk_def = 1;
                    add_entry(g, b, 3'd0);
                end
            end
            art_pkg::CmdHeap: begin
                if (!stk_def) st = art_pkg::StNoDef;
                else begin
                    hb = art_pkg::PageSize;
                    for (int i = 0; i < n_used; i++)
                        if (tbl_top[i] > hb) hb = tbl_top[i];
                    hb = page_up(hb);
                    if (hb > stk_base) st = art_pkg::StHeapHit;
                    else if (clashes(hb, hb)) st = art_pkg::StOverlap;
                    else begin
                        heap_lo = hb;
                        heap_top = hb;
                        heap_def = 1;
                    end
                end
            end
            art_pkg::CmdBrk: begin
                if (!heap_def) st = art_pkg::StNoDef;
                else if (addr == 0) val = heap_top;
                else if (addr < heap_lo) begin
                    heap_top = heap_lo;
                    val = heap_lo;
                end else if (clashes(heap_lo, addr)) st = art_pkg::StOverlap;
                else begin
                    heap_top = addr;
                    val = addr;
                end
            end
            art_pkg::CmdCheck: begin
                if (stk_def && stk_base <= addr && addr < stk_top) begin
                    found = 1;
                    top = stk_top;
                    rout = art_pkg::FullRights;
                end else if (heap_def && heap_lo <= addr && addr < heap_top) begin
                    found = 1;
                    top = heap_top;
                    rout = art_pkg::FullRights;
                end else begin
                    for (int i = n_used - 1; i >= 0 && !found; i--)
                        if (tbl_base[i] <= addr && addr < tbl_top[i]) begin
                            found = 1;
                            top = tbl_top[i];
                            rout = tbl_rights[i];
                        end
                end
                if (found) inb = (addr + size) < top;
                else st = art_pkg::StNotFnd;
            end
            default: ;
        endcase
        pending.push_back({st, val, rout, inb});
    endfunction

    task report(string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    task check_reply(logic [2:0] st, logic [31:0] val, logic [2:0] rout, logic inb);
        logic [38:0] e;
        if (pending.size() == 0) begin
            report("reply with nothing outstanding");
            return;
        end
        e = pending.pop_front();
        if (st !== e[38:36]) report($sformatf("status %0d want %0d", st, e[38:36]));
        if (val !== e[35:4]) report($sformatf("value %h want %h", val, e[35:4]));
        if (rout !== e[3:1]) report($sformatf("rights %0d want %0d", rout, e[3:1]));
        if (inb !== e[0]) report($sformatf("in_bounds %0d want %0d", inb, e[0]));
    endtask
endclass

module testbench;
    import art_pkg::*;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_start = 0;
    logic [2:0] i_cmd = 0;
    logic [31:0] i_addr = 0, i_size = 0;
    logic [2:0] i_rights = 0;
    logic o_busy, o_valid, o_in_bounds;
    logic [2:0] o_status, o_rights_out;
    logic [31:0] o_value;

    region_scoreboard regions = new();
    int idle_cycles = 0;

    address_region_table_unit DUT (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            regions.check_reply(o_status, o_value, o_rights_out, o_in_bounds);
        if ((i_start && !o_busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    function automatic int gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) n = 0;
        return n;
    endfunction

    task automatic issue(logic [2:0] cmd, logic [31:0] addr, logic [31:0] size,
                         logic [2:0] rights);
        int n;
        i_start <= 1;
        i_cmd <= cmd;
        i_addr <= addr;
        i_size <= size;
        i_rights <= rights;
        do @(posedge i_clk); while (o_busy);
        regions.note_command(cmd, addr, size, rights);
        n = gap();
        if (n > 0) begin
            i_start <= 0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // address near known regions so lookups usually hit
    function automatic logic [31:0] near_addr();
        int k;
        if (regions.n_used == 0 || $urandom_range(0, 4) == 0) return $urandom;
        k = $urandom_range(0, regions.n_used - 1);
        return regions.tbl_base[k] + $urandom_range(0, 3 * PageSize);
    endfunction

    task automatic one_session(int cmds);
        logic [31:0] stk;
        stk = {4'($urandom_range(8, 15)), 28'h0} + $urandom_range(0, 5000);
        issue(CmdStack, stk, $urandom_range(0, 5) * PageSize + $urandom_range(0, 1), 3'd0);
        for (int i = 0; i < cmds; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: issue(CmdRegion, {4'h0, 20'($urandom_range(0, 2 ** 20 - 1)), 8'h0}
                               ^ $urandom_range(0, 255), $urandom_range(0, 6 * PageSize),
                               3'($urandom_range(0, 7)));
                3: issue(CmdHeap, $urandom, $urandom, 3'($urandom_range(0, 7)));
                4, 5: issue(CmdBrk, ($urandom_range(0, 4) == 0) ? 32'd0 :
                            regions.heap_lo + $urandom_range(0, 8 * PageSize) -
                            PageSize, $urandom, 3'd0);
                6: issue(3'($urandom_range(0, 7)), $urandom, $urandom,
                         3'($urandom_range(0, 7)));
                default: issue(CmdCheck, near_addr(),
                               ($urandom_range(0, 3) == 0) ? $urandom :
                               $urandom_range(0, 2 * PageSize), 3'd0);
            endcase
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed
        issue(CmdHeap, 0, 0, 0);
        issue(CmdBrk, 5, 0, 0);
        issue(CmdCheck, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        issue(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
        issue(3'd7, 0, 0, 0);
        issue(CmdRegion, 32'h0001_0123, 32'h1, 3'd5);
        issue(CmdRegion, 32'h0001_0FFF, 32'h10, 3'd2);
        issue(CmdRegion, 32'hFFFF_F000, 32'hFFFF_FFFF, 3'd7);
        issue(CmdStack, 32'h8000_0ABC, 32'h2000, 0);
        issue(CmdStack, 32'h8000_0000, 32'h1000, 0);
        issue(CmdStack, 32'h9000_0000, 32'h0, 0);
        issue(CmdRegion, 32'h8FFF_F000, 32'h1000, 3'd1);
        issue(CmdBrk, 0, 0, 0);
        issue(CmdHeap, 0, 0, 0);
        issue(CmdBrk, 0, 0, 0);
        issue(CmdBrk, 32'h0000_5000, 0, 0);
        issue(CmdBrk, 32'h0000_0001, 0, 0);
        issue(CmdBrk, 32'h9000_0000, 0, 0);
        issue(CmdCheck, 32'h0001_0000, 32'h0, 0);
        issue(CmdCheck, 32'h0001_0000, 32'h1000, 0);
        issue(CmdCheck, 32'h8FFF_F000, 32'hFFFF_FFFF, 0);
        for (int i = 0; i < 14; i++) issue(CmdRegion, 32'h2000_0000 + i * 32'h10000, 1, 3'd3);
        issue(CmdRegion, 32'h4000_0000, 1, 3'd3);
        issue(CmdStack, 32'h5000_0000, 1, 0);
        issue(CmdHeap, 0, 0, 0);
        // random; slots never free, so later sessions only see a full table
        for (int s = 0; s < 18; s++) one_session(32);
        i_start <= 0;
        wait (regions.pending.size() == 0);
        repeat (2 * MaxRegions + 10) @(posedge i_clk);
        if (regions.errors == 0 && regions.pending.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule
